// ===== sv/skv_pkg.sv =====
package skv_pkg;

  // Default sizes of the table.
  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths on the ports.
  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 80;

  typedef logic [CMD_W-1:0] cmd_t;

  // Command codes.
  localparam cmd_t CMD_INSERT    = 3'd0;
  localparam cmd_t CMD_UPDATE    = 3'd1;
  localparam cmd_t CMD_UPSERT    = 3'd2;
  localparam cmd_t CMD_ERASE     = 3'd3;
  localparam cmd_t CMD_LOOKUP    = 3'd4;
  localparam cmd_t CMD_READ_RANK = 3'd5;

  // Broadcast from the control to every cell in the apply cycle.
  typedef struct packed {
    logic ins;   // open a slot at the insert position, shift the tail up
    logic era;   // close the slot at the match position, shift the tail down
    logic upd;   // overwrite the value at the match position
  } cell_op_t;

  // Compare results each cell registers when an item is accepted.
  typedef struct packed {
    logic lt;      // holds a pair whose key is below the item's key
    logic at_pos;  // first cell that is not below the item's key
    logic match;   // at_pos and holds the item's key
    logic hit;     // holds a pair and its index equals the requested rank
  } cell_flags_t;

endpackage

// ===== sv/sorted_key_value_table.sv =====
// Sorted key-value table. Holds up to CAPACITY distinct pairs in ascending key
// order in a row of cells, one pair per cell, and executes one command per item
// (insert, update, insert-or-update, erase, lookup by key, read by rank). The
// command code travels in s_tuser; key, value and rank in s_tdata. Each item
// returns one result item. An item is handled in two steps: in the cycle it is accepted
// every cell compares its key with the item's key and its index with the rank,
// and then, in the apply cycle, the result is formed from those compare flags and the
// row shifts one place up or down in a single step to insert or erase. The
// apply cycle waits while a previous result has not been taken. No clearing
// pass is needed after reset.
module sorted_key_value_table
  import skv_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // key[31:0], value[63:32], rank[69:64], zeros
  input  cmd_t                 s_tuser,  // command[2:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // ok[0], found_key[32:1], found_value[64:33],
                                         // entry_count[71:65], table_full[72], zeros
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic state;
  logic state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Item fields held for the apply cycle.
  cmd_t                   cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;

  logic [KEY_WIDTH-1:0]   in_key;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [RANK_W-1:0]      in_rank;
  logic                   accept;
  logic                   out_free;
  logic                   apply;

  cell_op_t op;

  // Row signals.
  logic                   lt_now [CAPACITY];
  logic [KEY_WIDTH-1:0]   c_key  [CAPACITY];
  logic [VALUE_WIDTH-1:0] c_val  [CAPACITY];
  logic                   c_vld  [CAPACITY];
  cell_flags_t            c_flg  [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec;

  // Reductions over the row.
  logic                   present;
  logic [VALUE_WIDTH-1:0] match_value;
  logic                   rank_ok;
  logic [KEY_WIDTH-1:0]   rank_key;
  logic [VALUE_WIDTH-1:0] rank_value;

  // Result fields.
  logic                   res_ok;
  logic [KEY_WIDTH-1:0]   res_key;
  logic [VALUE_WIDTH-1:0] res_value;
  logic                   res_full;
  logic                   is_full;

  // Unpack the input item, sizing key and value to the stored widths.
  assign in_key   = KEY_WIDTH'(s_tdata[KEY_W-1:0]);
  assign in_value = VALUE_WIDTH'(s_tdata[KEY_W+VALUE_W-1:KEY_W]);
  assign in_rank  = s_tdata[KEY_W+VALUE_W+RANK_W-1:KEY_W+VALUE_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign apply    = (state == ST_APPLY) && out_free;
  assign is_full  = (count == CW'(CAPACITY));

  // Control sequence: compare on accept, then apply.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_APPLY;
      ST_APPLY: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= s_tuser;
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  // Row of cells; each neighbor pair is wired both ways for shifting.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   p_lt;
    logic [KEY_WIDTH-1:0]   p_key;
    logic [VALUE_WIDTH-1:0] p_val;
    logic                   p_vld;
    logic [KEY_WIDTH-1:0]   n_key;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   n_vld;

    if (i == 0) begin : g_first
      assign p_lt  = 1'b1;
      assign p_key = '0;
      assign p_val = '0;
      assign p_vld = 1'b0;
    end else begin : g_mid
      assign p_lt  = lt_now[i-1];
      assign p_key = c_key[i-1];
      assign p_val = c_val[i-1];
      assign p_vld = c_vld[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_key = '0;
      assign n_val = '0;
      assign n_vld = 1'b0;
    end else begin : g_inner
      assign n_key = c_key[i+1];
      assign n_val = c_val[i+1];
      assign n_vld = c_vld[i+1];
    end

    skv_cell #(
      .INDEX       (i),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .capture    (accept),
      .cmp_key    (in_key),
      .rank       (in_rank),
      .op         (op),
      .new_key    (key_q),
      .new_value  (value_q),
      .prev_lt    (p_lt),
      .prev_key   (p_key),
      .prev_value (p_val),
      .prev_valid (p_vld),
      .next_key   (n_key),
      .next_value (n_val),
      .next_valid (n_vld),
      .lt_now     (lt_now[i]),
      .key        (c_key[i]),
      .value      (c_val[i]),
      .valid      (c_vld[i]),
      .flags      (c_flg[i])
    );

    assign valid_vec[i] = c_vld[i];
  end

  // One-hot selections over the row.
  always_comb begin
    present     = 1'b0;
    match_value = '0;
    rank_ok     = 1'b0;
    rank_key    = '0;
    rank_value  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      present     = present | c_flg[i].match;
      match_value = match_value | (c_val[i] & {VALUE_WIDTH{c_flg[i].match}});
      rank_ok     = rank_ok | c_flg[i].hit;
      rank_key    = rank_key | (c_key[i] & {KEY_WIDTH{c_flg[i].hit}});
      rank_value  = rank_value | (c_val[i] & {VALUE_WIDTH{c_flg[i].hit}});
    end
  end

  // Command decode for the apply cycle.
  always_comb begin
    op         = '0;
    count_next = count;
    res_ok     = 1'b0;
    res_key    = key_q;
    res_value  = '0;
    res_full   = 1'b0;
    unique case (cmd_q)
      CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
        if (present) begin
          if (cmd_q != CMD_INSERT) begin
            op.upd    = apply;
            res_ok    = 1'b1;
            res_value = value_q;
          end else begin
            res_value = match_value;
          end
        end else if (cmd_q != CMD_UPDATE) begin
          if (is_full) begin
            res_full = 1'b1;
          end else begin
            op.ins    = apply;
            res_ok    = 1'b1;
            res_value = value_q;
            if (apply) count_next = count + CW'(1);
          end
        end
      end
      CMD_ERASE: begin
        if (present) begin
          op.era    = apply;
          res_ok    = 1'b1;
          res_value = match_value;
          if (apply) count_next = count - CW'(1);
        end
      end
      CMD_LOOKUP: begin
        if (present) begin
          res_ok    = 1'b1;
          res_value = match_value;
        end
      end
      CMD_READ_RANK: begin
        if (rank_ok) begin
          res_ok    = 1'b1;
          res_key   = rank_key;
          res_value = rank_value;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      m_tdata <= {
        (M_TDATA_W - 2 - KEY_W - VALUE_W - COUNT_W)'(0),
        res_full,
        COUNT_W'(count_next),
        VALUE_W'(res_value),
        KEY_W'(res_key),
        res_ok
      };
    end
  end

`ifndef SYNTHESIS
  // The occupied cells always number exactly the stored count.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("occupied cells differ from stored count");

  // Occupied cells form a prefix of the row.
  for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
    a_prefix: assert property (@(posedge clk) disable iff (rst)
      c_vld[i] |-> c_vld[i-1])
      else $error("gap in occupied cells");

    a_sorted: assert property (@(posedge clk) disable iff (rst)
      c_vld[i] |-> (c_key[i-1] < c_key[i]))
      else $error("keys not strictly ascending");
  end

  // A refused insert for lack of room never reports success.
  a_full_not_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[KEY_W+VALUE_W+COUNT_W+1] |-> !m_tdata[0])
    else $error("full refusal reported as success");
`endif

endmodule

// ===== sv/skv_cell.sv =====
module skv_cell
  import skv_pkg::*;
#(
  parameter int INDEX       = 0,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   capture,
  input  logic [KEY_WIDTH-1:0]   cmp_key,
  input  logic [RANK_W-1:0]      rank,
  input  cell_op_t               op,
  input  logic [KEY_WIDTH-1:0]   new_key,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic                   prev_lt,
  input  logic [KEY_WIDTH-1:0]   prev_key,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic                   prev_valid,
  input  logic [KEY_WIDTH-1:0]   next_key,
  input  logic [VALUE_WIDTH-1:0] next_value,
  input  logic                   next_valid,
  output logic                   lt_now,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   valid,
  output cell_flags_t            flags
);

  logic eq_now;
  logic at_pos_now;
  logic hit_now;

  // Compare the held key against the incoming item's key.
  assign lt_now     = valid && (key < cmp_key);
  assign eq_now     = valid && (key == cmp_key);
  assign at_pos_now = !lt_now && prev_lt;
  assign hit_now    = valid && (INDEX == int'(rank));

  // Compare results are held for the apply cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (capture) begin
      flags.lt     <= lt_now;
      flags.at_pos <= at_pos_now;
      flags.match  <= at_pos_now && eq_now;
      flags.hit    <= hit_now;
    end
  end

  // Occupancy moves along the row with the pairs.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ins && flags.at_pos) begin
      valid <= 1'b1;
    end else if (op.ins && !flags.lt) begin
      valid <= prev_valid;
    end else if (op.era && !flags.lt) begin
      valid <= next_valid;
    end
  end

  // Pair payload: take the new pair, a neighbor's pair, or a new value.
  always_ff @(posedge clk) begin
    if (op.ins && flags.at_pos) begin
      key   <= new_key;
      value <= new_value;
    end else if (op.ins && !flags.lt) begin
      key   <= prev_key;
      value <= prev_value;
    end else if (op.era && !flags.lt) begin
      key   <= next_key;
      value <= next_value;
    end else if (op.upd && flags.at_pos) begin
      value <= new_value;
    end
  end

endmodule
